FILE: hw/rtl/lfci_pkg.sv
`timescale 1ns / 1ps

package lfci_pkg;

  // Table capacity per bank.
  localparam int MAX_POINTS_DEF = 2048;
  localparam int MIN_POINTS     = 2;

  // Field widths.
  localparam int OPC_W     = 2;
  localparam int FREQ_W    = 24;
  localparam int GAIN_W    = 16;
  localparam int BIN_W     = 16;
  localparam int STAT_W    = 3;
  localparam int CNT_OUT_W = 12;
  localparam int SR_W      = 20;
  localparam int FL_W      = 5;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 32;

  // Log unit widths: Q5.16 result, 1025-entry table of 17-bit values.
  localparam int LOG_W       = 21;
  localparam int LOG_ENTRIES = 1024;
  localparam int TAB_W       = 17;
  localparam int T_W         = 17;

  localparam logic [FREQ_W-1:0]        FREQ_MAX   = 24'd16000000;
  localparam logic signed [GAIN_W-1:0] GAIN_LIMIT = 16'sd25600;

  // Input opcodes.
  typedef enum logic [OPC_W-1:0] {
    OPC_LOAD  = 2'd0,
    OPC_QUERY = 2'd1,
    OPC_CLEAR = 2'd2,
    OPC_NOP   = 2'd3
  } opcode_t;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_OK     = 3'd0;
  localparam logic [STAT_W-1:0] ST_COMMIT = 3'd1;
  localparam logic [STAT_W-1:0] ST_BAD    = 3'd2;
  localparam logic [STAT_W-1:0] ST_ASC    = 3'd3;
  localparam logic [STAT_W-1:0] ST_MANY   = 3'd4;
  localparam logic [STAT_W-1:0] ST_FEW    = 3'd5;

  // Log operand selection.
  localparam logic [1:0] LSEL_F1 = 2'd0;
  localparam logic [1:0] LSEL_F2 = 2'd1;
  localparam logic [1:0] LSEL_F  = 2'd2;

  // Datapath operations issued by the controller.
  typedef enum logic [4:0] {
    OP_NONE  = 5'd0,
    OP_LOAD  = 5'd1,
    OP_CLEAR = 5'd2,
    OP_ZERO  = 5'd3,
    OP_MUL   = 5'd4,
    OP_SHIFT = 5'd5,
    OP_FIRST = 5'd6,
    OP_LASTC = 5'd7,
    OP_SRCH  = 5'd8,
    OP_CMP   = 5'd9,
    OP_RDLO  = 5'd10,
    OP_GETLO = 5'd11,
    OP_GETHI = 5'd12,
    OP_LOGGO = 5'd13,
    OP_LOGW  = 5'd14,
    OP_DIVGO = 5'd15,
    OP_DIVW  = 5'd16,
    OP_GMUL  = 5'd17,
    OP_GFIN  = 5'd18,
    OP_OUT   = 5'd19
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] log_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic op_load;
    logic op_query;
    logic op_clear;
    logic uncal;
    logic le_first;
    logic ge_last;
    logic srch_more;
    logic log_done;
    logic div_done;
    logic out_free;
  } dp_sts_t;

  typedef logic [TAB_W-1:0] log_tab_t [LOG_ENTRIES+1];

  // Builds 65536*log2(1+i/1024) by repeated squaring, 20 result bits rounded to 16.
  function automatic log_tab_t build_log_tab();
    log_tab_t    tab;
    logic [63:0] y;
    logic [20:0] r;
    for (int i = 0; i <= LOG_ENTRIES; i++) begin
      y = (64'd1 << 30) + (64'(i) << 20);
      r = '0;
      for (int b = 0; b < 20; b++) begin
        y = (y * y) >> 30;
        r = {r[19:0], 1'b0};
        if (y >= (64'd2 << 30)) begin
          y = y >> 1;
          r[0] = 1'b1;
        end
      end
      tab[i] = TAB_W'((r + 21'd8) >> 4);
    end
    return tab;
  endfunction

endpackage

FILE: hw/rtl/lfci_log.sv
`timescale 1ns / 1ps

module lfci_log (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [lfci_pkg::FREQ_W-1:0] x,
  output logic                        done,
  output logic [lfci_pkg::LOG_W-1:0]  result
);
  import lfci_pkg::*;

  localparam log_tab_t LOG_TAB = build_log_tab();

  logic [3:0]        step_r;
  logic              done_r;
  logic [4:0]        e_r;
  logic [22:0]       m_r;
  logic              zero_r;
  logic [TAB_W-1:0]  rom_r;
  logic [TAB_W-1:0]  t0_r;
  logic [29:0]       mul_r;
  logic [LOG_W-1:0]  result_r;
  logic [4:0]        e_c;
  logic [FREQ_W-1:0] sh_c;
  logic [10:0]       rom_addr;
  logic [TAB_W-1:0]  diff_c;

  // Leading-one position and normalized fraction.
  always_comb begin
    e_c = '0;
    for (int i = 0; i < FREQ_W; i++) begin
      if (x[i]) begin
        e_c = 5'(i);
      end
    end
    sh_c = x << (5'd23 - e_c);
  end

  // The second table read fetches the next entry for the slope.
  assign rom_addr = step_r[1] ? ({1'b0, m_r[22:13]} + 11'd1) : {1'b0, m_r[22:13]};
  assign diff_c   = rom_r - t0_r;

  always_ff @(posedge clk) begin
    rom_r <= LOG_TAB[rom_addr];
  end

  // Step sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      done_r <= 1'b0;
    end else begin
      step_r <= start ? 4'b0001 : {step_r[2:0], 1'b0};
      done_r <= step_r[3];
    end
  end

  // Datapath of the log unit.
  always_ff @(posedge clk) begin
    if (start) begin
      e_r    <= e_c;
      m_r    <= sh_c[22:0];
      zero_r <= (x == '0);
    end
    if (step_r[1]) begin
      t0_r <= rom_r;
    end
    if (step_r[2]) begin
      mul_r <= diff_c * m_r[12:0];
    end
    if (step_r[3]) begin
      result_r <= zero_r ? '0 :
                  ((LOG_W'(e_r) << 16) + LOG_W'(t0_r) + LOG_W'(mul_r[29:13]));
    end
  end

  assign done   = done_r;
  assign result = result_r;

endmodule

FILE: hw/rtl/lfci_div.sv
`timescale 1ns / 1ps

module lfci_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [lfci_pkg::LOG_W-1:0] num,
  input  logic [lfci_pkg::LOG_W-1:0] den,
  output logic                       done,
  output logic [lfci_pkg::T_W-1:0]   quot
);
  import lfci_pkg::*;

  logic [4:0]       cnt_r;
  logic             done_r;
  logic [LOG_W:0]   rem_r;
  logic [LOG_W-1:0] den_r;
  logic [T_W-1:0]   q_r;
  logic             ge_c;
  logic [LOG_W:0]   rem_c;

  // One quotient bit per cycle; the numerator is num shifted up by 16.
  assign ge_c  = rem_r >= {1'b0, den_r};
  assign rem_c = ge_c ? (rem_r - {1'b0, den_r}) : rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == 5'd1);
      if (start) begin
        cnt_r <= 5'(T_W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {1'b0, num};
      den_r <= den;
      q_r   <= '0;
    end else if (cnt_r != '0) begin
      rem_r <= {rem_c[LOG_W-1:0], 1'b0};
      q_r   <= {q_r[T_W-2:0], ge_c};
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

FILE: hw/rtl/lfci_dp.sv
`timescale 1ns / 1ps

module lfci_dp #(
  parameter int MAX_POINTS = lfci_pkg::MAX_POINTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_acc,
  input  logic [lfci_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [lfci_pkg::OPC_W-1:0]      in_tuser,
  input  logic                            in_tlast,
  input  logic                            cfg_valid,
  input  logic                            cfg_index,
  input  logic [lfci_pkg::SR_W-1:0]       cfg_data,
  input  logic                            out_tready,
  output logic                            out_tvalid,
  output logic [lfci_pkg::OUT_DATA_W-1:0] out_tdata,
  input  lfci_pkg::dp_cmd_t               cmd,
  output lfci_pkg::dp_sts_t               sts
);
  import lfci_pkg::*;

  localparam int DEPTH = 2 * MAX_POINTS;
  localparam int AW    = $clog2(DEPTH);
  localparam int IW    = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
  localparam int CW    = $clog2(MAX_POINTS + 1);

  // Table banks.
  logic [FREQ_W-1:0] freq_mem [DEPTH];
  logic [GAIN_W-1:0] gain_mem [DEPTH];
  logic [FREQ_W-1:0] rd_freq_r;
  logic signed [GAIN_W-1:0] rd_gain_r;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     wr_addr;
  logic [AW-1:0]     off;
  logic              wr_en;

  // Latched request and configuration.
  logic [OPC_W-1:0]         opc_r;
  logic [FREQ_W-1:0]        freq_in_r;
  logic signed [GAIN_W-1:0] gain_in_r;
  logic                     last_r;
  logic [BIN_W-1:0]         bin_r;
  logic [SR_W-1:0]          sr_r;
  logic [FL_W-1:0]          fl_r;

  // Table state.
  logic              bank_r;
  logic [CW-1:0]     ccount_r;
  logic [CW-1:0]     lcount_r;
  logic [FREQ_W-1:0] prev_r;
  logic [STAT_W-1:0] lerr_r;

  // Query working registers.
  logic [35:0]              prod_r;
  logic [39:0]              f_r;
  logic [IW-1:0]            lo_r;
  logic [IW-1:0]            hi_r;
  logic [IW-1:0]            mid_r;
  logic [IW-1:0]            mid_c;
  logic [FREQ_W-1:0]        f1_r;
  logic [FREQ_W-1:0]        f2_r;
  logic signed [GAIN_W-1:0] g1_r;
  logic signed [GAIN_W-1:0] g2_r;
  logic [LOG_W-1:0]         l1_r;
  logic [LOG_W-1:0]         l2_r;
  logic [LOG_W-1:0]         lf_r;
  logic [T_W-1:0]           t_r;
  logic signed [34:0]       gprod_r;
  logic [STAT_W-1:0]        res_status_r;
  logic [GAIN_W-1:0]        res_gain_r;
  logic                     out_valid_r;
  logic [OUT_DATA_W-1:0]    out_data_r;

  // Load evaluation.
  logic              ld_bad;
  logic [STAT_W-1:0] ld_err;
  logic              ld_wr;
  logic [CW-1:0]     ld_cnt;
  logic [FREQ_W-1:0] ld_prev;
  logic [STAT_W-1:0] ld_status;
  logic              ld_commit;

  // Arithmetic helpers.
  logic [FREQ_W-1:0]  log_x;
  logic               log_done;
  logic [LOG_W-1:0]   log_res;
  logic               div_done;
  logic [T_W-1:0]     div_q;
  logic signed [16:0] gdiff;
  logic signed [17:0] tsg;
  logic signed [34:0] rnd;
  logic signed [18:0] gsum;
  logic               cal;

  // Request capture.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      opc_r     <= in_tuser;
      freq_in_r <= in_tdata[23:0];
      gain_in_r <= in_tdata[39:24];
      bin_r     <= in_tdata[55:40];
      last_r    <= in_tlast;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sr_r <= 20'd48000;
      fl_r <= 5'd10;
    end else if (cfg_valid) begin
      if (cfg_index == 1'b0) begin
        sr_r <= cfg_data;
      end else begin
        fl_r <= cfg_data[FL_W-1:0];
      end
    end
  end

  // Memory addressing.
  assign off   = bank_r ? AW'(MAX_POINTS) : '0;
  assign mid_c = lo_r + ((hi_r - lo_r) >> 1);

  always_comb begin
    case (cmd.op)
      OP_FIRST: rd_addr = off + AW'(ccount_r) - AW'(1);
      OP_SRCH:  rd_addr = off + AW'(mid_c);
      OP_RDLO:  rd_addr = off + AW'(lo_r);
      OP_GETLO: rd_addr = off + AW'(hi_r);
      default:  rd_addr = off;
    endcase
  end

  assign wr_addr = (bank_r ? '0 : AW'(MAX_POINTS)) + AW'(lcount_r);
  assign wr_en   = (cmd.op == OP_LOAD) && ld_wr;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      freq_mem[wr_addr] <= freq_in_r;
    end
    rd_freq_r <= freq_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      gain_mem[wr_addr] <= gain_in_r;
    end
    rd_gain_r <= gain_mem[rd_addr];
  end

  // Load point checks; the first error of a load is kept.
  always_comb begin
    ld_bad = (freq_in_r == '0) || (freq_in_r > FREQ_MAX) ||
             (gain_in_r < -GAIN_LIMIT) || (gain_in_r > GAIN_LIMIT);
    ld_err  = lerr_r;
    ld_wr   = 1'b0;
    ld_cnt  = lcount_r;
    ld_prev = prev_r;
    if (lerr_r == ST_OK) begin
      if (ld_bad) begin
        ld_err = ST_BAD;
      end else if (freq_in_r <= prev_r) begin
        ld_err = ST_ASC;
      end else if (lcount_r >= CW'(MAX_POINTS)) begin
        ld_err = ST_MANY;
      end else begin
        ld_wr   = 1'b1;
        ld_prev = freq_in_r;
        ld_cnt  = lcount_r + CW'(1);
      end
    end
    ld_status = ld_err;
    ld_commit = 1'b0;
    if (last_r && (ld_err == ST_OK)) begin
      if (ld_cnt < CW'(MIN_POINTS)) begin
        ld_status = ST_FEW;
      end else begin
        ld_status = ST_COMMIT;
        ld_commit = 1'b1;
      end
    end
  end

  // Table state update.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r   <= 1'b0;
      ccount_r <= '0;
      lcount_r <= '0;
      prev_r   <= '0;
      lerr_r   <= ST_OK;
    end else if (cmd.op == OP_LOAD) begin
      if (last_r) begin
        lcount_r <= '0;
        prev_r   <= '0;
        lerr_r   <= ST_OK;
      end else begin
        lcount_r <= ld_cnt;
        prev_r   <= ld_prev;
        lerr_r   <= ld_err;
      end
      if (ld_commit) begin
        bank_r   <= ~bank_r;
        ccount_r <= ld_cnt;
      end
    end else if (cmd.op == OP_CLEAR) begin
      ccount_r <= '0;
    end
  end

  // Log operand selection.
  always_comb begin
    case (cmd.log_sel)
      LSEL_F1: log_x = f1_r;
      LSEL_F2: log_x = f2_r;
      default: log_x = f_r[FREQ_W-1:0];
    endcase
  end

  lfci_log u_log (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.op == OP_LOGGO),
    .x      (log_x),
    .done   (log_done),
    .result (log_res)
  );

  lfci_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.op == OP_DIVGO),
    .num   (lf_r - l1_r),
    .den   (l2_r - l1_r),
    .done  (div_done),
    .quot  (div_q)
  );

  // Interpolation arithmetic.
  assign gdiff = {g2_r[GAIN_W-1], g2_r} - {g1_r[GAIN_W-1], g1_r};
  assign tsg   = {1'b0, t_r};
  assign rnd   = gprod_r + 35'sd32768;
  assign gsum  = {{3{g1_r[GAIN_W-1]}}, g1_r} + rnd[34:16];
  assign cal   = ccount_r >= CW'(MIN_POINTS);

  // Query sequence registers.
  always_ff @(posedge clk) begin
    case (cmd.op) inside
      OP_LOAD: begin
        res_status_r <= ld_status;
        res_gain_r   <= '0;
      end
      OP_CLEAR, OP_ZERO: begin
        res_status_r <= ST_OK;
        res_gain_r   <= '0;
      end
      OP_MUL: begin
        prod_r       <= 36'(bin_r) * 36'(sr_r);
        res_status_r <= ST_OK;
      end
      OP_SHIFT: f_r <= {prod_r, 4'b0000} >> fl_r;
      OP_FIRST: res_gain_r <= rd_gain_r;
      OP_LASTC: begin
        res_gain_r <= rd_gain_r;
        lo_r       <= '0;
        hi_r       <= IW'(ccount_r - CW'(1));
      end
      OP_SRCH: mid_r <= mid_c;
      OP_CMP: begin
        if ({16'b0, rd_freq_r} < f_r) begin
          lo_r <= mid_r;
        end else begin
          hi_r <= mid_r;
        end
      end
      OP_GETLO: begin
        f1_r <= rd_freq_r;
        g1_r <= rd_gain_r;
      end
      OP_GETHI: begin
        f2_r <= rd_freq_r;
        g2_r <= rd_gain_r;
      end
      OP_LOGW: begin
        if (log_done) begin
          case (cmd.log_sel)
            LSEL_F1: l1_r <= log_res;
            LSEL_F2: l2_r <= log_res;
            default: lf_r <= log_res;
          endcase
        end
      end
      OP_DIVW: begin
        if (div_done) begin
          t_r <= (l2_r > l1_r) ? div_q : '0;
        end
      end
      OP_GMUL: gprod_r <= tsg * gdiff;
      OP_GFIN: res_gain_r <= gsum[GAIN_W-1:0];
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == OP_OUT) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_OUT) begin
      out_data_r <= {cal, CNT_OUT_W'(ccount_r), res_gain_r, res_status_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Status to the controller.
  assign sts.op_load   = opc_r == OPC_LOAD;
  assign sts.op_query  = opc_r == OPC_QUERY;
  assign sts.op_clear  = opc_r == OPC_CLEAR;
  assign sts.uncal     = (ccount_r < CW'(MIN_POINTS)) || (ccount_r > CW'(MAX_POINTS));
  assign sts.le_first  = f_r <= {16'b0, rd_freq_r};
  assign sts.ge_last   = f_r >= {16'b0, rd_freq_r};
  assign sts.srch_more = (hi_r - lo_r) > IW'(1);
  assign sts.log_done  = log_done;
  assign sts.div_done  = div_done;
  assign sts.out_free  = !out_valid_r || out_tready;

endmodule

FILE: hw/rtl/lfci_ctrl.sv
`timescale 1ns / 1ps

module lfci_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_acc,
  output logic              in_tready,
  input  lfci_pkg::dp_sts_t sts,
  output lfci_pkg::dp_cmd_t cmd
);
  import lfci_pkg::*;

  typedef enum logic [20:0] {
    S_IDLE  = 21'b1 << 0,
    S_DISP  = 21'b1 << 1,
    S_LOAD  = 21'b1 << 2,
    S_CLEAR = 21'b1 << 3,
    S_ZERO  = 21'b1 << 4,
    S_MUL   = 21'b1 << 5,
    S_SHIFT = 21'b1 << 6,
    S_FIRST = 21'b1 << 7,
    S_LASTC = 21'b1 << 8,
    S_SRCH  = 21'b1 << 9,
    S_CMP   = 21'b1 << 10,
    S_RDLO  = 21'b1 << 11,
    S_GETLO = 21'b1 << 12,
    S_GETHI = 21'b1 << 13,
    S_LOGGO = 21'b1 << 14,
    S_LOGW  = 21'b1 << 15,
    S_DIVGO = 21'b1 << 16,
    S_DIVW  = 21'b1 << 17,
    S_GMUL  = 21'b1 << 18,
    S_GFIN  = 21'b1 << 19,
    S_OUT   = 21'b1 << 20
  } state_t;

  state_t     state_r;
  state_t     state_nxt;
  logic [1:0] sel_r;
  logic [1:0] sel_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sel_r   <= LSEL_F1;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
    end
  end

  // Sequencing of a request through the datapath.
  always_comb begin
    state_nxt   = state_r;
    sel_nxt     = sel_r;
    cmd.op      = OP_NONE;
    cmd.log_sel = sel_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        if (sts.op_load) begin
          state_nxt = S_LOAD;
        end else if (sts.op_clear) begin
          state_nxt = S_CLEAR;
        end else if (sts.op_query && !sts.uncal) begin
          state_nxt = S_MUL;
        end else begin
          state_nxt = S_ZERO;
        end
      end
      S_LOAD: begin
        cmd.op    = OP_LOAD;
        state_nxt = S_OUT;
      end
      S_CLEAR: begin
        cmd.op    = OP_CLEAR;
        state_nxt = S_OUT;
      end
      S_ZERO: begin
        cmd.op    = OP_ZERO;
        state_nxt = S_OUT;
      end
      S_MUL: begin
        cmd.op    = OP_MUL;
        state_nxt = S_SHIFT;
      end
      S_SHIFT: begin
        cmd.op    = OP_SHIFT;
        state_nxt = S_FIRST;
      end
      S_FIRST: begin
        cmd.op    = OP_FIRST;
        state_nxt = sts.le_first ? S_OUT : S_LASTC;
      end
      S_LASTC: begin
        cmd.op    = OP_LASTC;
        state_nxt = sts.ge_last ? S_OUT : S_SRCH;
      end
      S_SRCH: begin
        cmd.op    = OP_SRCH;
        state_nxt = sts.srch_more ? S_CMP : S_RDLO;
      end
      S_CMP: begin
        cmd.op    = OP_CMP;
        state_nxt = S_SRCH;
      end
      S_RDLO: begin
        cmd.op    = OP_RDLO;
        state_nxt = S_GETLO;
      end
      S_GETLO: begin
        cmd.op    = OP_GETLO;
        state_nxt = S_GETHI;
      end
      S_GETHI: begin
        cmd.op    = OP_GETHI;
        sel_nxt   = LSEL_F1;
        state_nxt = S_LOGGO;
      end
      S_LOGGO: begin
        cmd.op    = OP_LOGGO;
        state_nxt = S_LOGW;
      end
      S_LOGW: begin
        cmd.op = OP_LOGW;
        if (sts.log_done) begin
          if (sel_r == LSEL_F) begin
            state_nxt = S_DIVGO;
          end else begin
            sel_nxt   = sel_r + 2'd1;
            state_nxt = S_LOGGO;
          end
        end
      end
      S_DIVGO: begin
        cmd.op    = OP_DIVGO;
        state_nxt = S_DIVW;
      end
      S_DIVW: begin
        cmd.op = OP_DIVW;
        if (sts.div_done) begin
          state_nxt = S_GMUL;
        end
      end
      S_GMUL: begin
        cmd.op    = OP_GMUL;
        state_nxt = S_GFIN;
      end
      S_GFIN: begin
        cmd.op    = OP_GFIN;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.op    = OP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_tready = state_r == S_IDLE;

endmodule

FILE: hw/rtl/log_freq_calibration_interpolator.sv
`timescale 1ns / 1ps
// Load, clear, opcode-3 and uncalibrated query requests go from dispatch through a single
// operation state to the output; the next request is taken once the result is registered.
// Calibrated query: ends at the first-point or last-point clamp, or else runs a binary
// search over the single-port table, three log evaluations and the 17-step divider.
// A waiting result holds one request.
// Reset (rst_n low, synchronous) empties the table and restores the default configuration.

module log_freq_calibration_interpolator #(
  parameter int MAX_POINTS = lfci_pkg::MAX_POINTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // in_tdata: point_freq[23:0], point_gain[39:24], bin_index[55:40]
  input  logic [lfci_pkg::IN_DATA_W-1:0]  in_tdata,
  // in_tuser: opcode[1:0]
  input  logic [lfci_pkg::OPC_W-1:0]      in_tuser,
  input  logic                            in_tlast,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // out_tdata: status[2:0], gain_db[18:3], point_count[30:19], calibrated[31]
  output logic [lfci_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic                            cfg_index,
  input  logic [lfci_pkg::SR_W-1:0]       cfg_data
);
  import lfci_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    in_acc;

  // A request is taken when both sides of the input handshake agree.
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  lfci_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_acc    (in_acc),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lfci_dp #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_acc     (in_acc),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import lfci_pkg::*;

  localparam int     LIMIT_CYCLES = 1000000;
  localparam int     RAND_ITEMS   = 1550;
  localparam int     BANK         = 2048;
  localparam logic   REG_SAMPLE_RATE = 1'b0;
  localparam logic   REG_FFT_LOG2    = 1'b1;

  typedef struct {
    opcode_t            op;
    logic [23:0]        freq;
    logic signed [15:0] gain;
    logic               last;
    logic [15:0]        bin;
    bit                 typed;
    logic [2:0]         t_status;
    logic signed [15:0] t_gain;
    logic [11:0]        t_count;
    logic               t_cal;
  } request_t;

  typedef struct {
    logic [2:0]         status;
    logic signed [15:0] gain;
    logic [11:0]        count;
    logic               cal;
  } reply_t;

  logic        clk;
  logic        rst_n;
  logic [55:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        in_tlast;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] out_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [19:0] cfg_data;

  log_freq_calibration_interpolator u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Shadow copy of the calibration table and load state.
  logic [16:0]        log_lut [0:1024];
  logic [23:0]        cal_freq [0:2*BANK-1];
  logic signed [15:0] cal_gain [0:2*BANK-1];
  logic [19:0]        rate_hz;
  logic [4:0]         fft_shift;
  int unsigned        live_bank;
  int unsigned        table_points;
  int unsigned        pending_points;
  logic [23:0]        last_freq;
  logic [2:0]         pending_err;

  reply_t  reply_q[$];
  int      mismatches;
  bit      hold_go;
  bit      quiet;
  int      sent;

  // Rebuilds 65536*log2(1+i/1024) with the squaring method.
  task automatic fill_log_lut();
    logic [63:0] y;
    logic [31:0] r;
    for (int i = 0; i <= 1024; i++) begin
      y = (64'd1 << 30) + (64'(i) << 20);
      r = 0;
      for (int b = 0; b < 20; b++) begin
        y = (y * y) >> 30;
        r = r << 1;
        if (y >= (64'd2 << 30)) begin
          y = y >> 1;
          r = r | 1;
        end
      end
      log_lut[i] = 17'((r + 8) >> 4);
    end
  endtask

  function automatic logic [31:0] log2_fix(input logic [23:0] x);
    int          e;
    logic [22:0] m;
    int          idx;
    logic [31:0] base;
    logic [31:0] step;
    if (x == 0) return 0;
    e = 0;
    for (int j = 0; j < 24; j++) if (x[j]) e = j;
    m = 23'(32'(x) << (23 - e));
    idx = int'(m[22:13]);
    base = 32'(log_lut[idx]);
    step = ((32'(log_lut[idx + 1]) - base) * 32'(m[12:0])) >> 13;
    return 32'(e) * 65536 + base + step;
  endfunction

  function automatic logic signed [15:0] bin_correction(input logic [15:0] k);
    int unsigned  off;
    int unsigned  lo;
    int unsigned  hi;
    int unsigned  mid;
    logic [63:0]  f64;
    logic [31:0]  l1;
    logic [31:0]  l2;
    logic [31:0]  lf;
    logic [63:0]  t;
    longint       g1;
    longint       g2;
    longint       acc;
    if (table_points < 2) return 0;
    off = live_bank * BANK;
    f64 = (64'(k) * 64'(rate_hz) * 64'd16) >> fft_shift;
    if (f64 <= 64'(cal_freq[off])) return cal_gain[off];
    if (f64 >= 64'(cal_freq[off + table_points - 1])) return cal_gain[off + table_points - 1];
    lo = 0;
    hi = table_points - 1;
    while (hi - lo > 1) begin
      mid = lo + ((hi - lo) >> 1);
      if (64'(cal_freq[off + mid]) < f64) lo = mid;
      else hi = mid;
    end
    l1 = log2_fix(cal_freq[off + lo]);
    l2 = log2_fix(cal_freq[off + hi]);
    lf = log2_fix(f64[23:0]);
    t = (l2 > l1) ? ((64'(lf - l1) << 16) / 64'(l2 - l1)) : 64'd0;
    g1 = longint'(cal_gain[off + lo]);
    g2 = longint'(cal_gain[off + hi]);
    acc = longint'(t) * (g2 - g1) + 32768;
    return 16'(g1 + (acc >>> 16));
  endfunction

  // Advances the shadow state by one request and returns its reply.
  function automatic reply_t apply_request(input request_t rq);
    reply_t rp;
    int unsigned slot;
    rp.status = ST_OK;
    rp.gain = 0;
    case (rq.op)
      OPC_LOAD: begin
        if (pending_err == ST_OK) begin
          if (rq.freq < 1 || rq.freq > FREQ_MAX || rq.gain < -GAIN_LIMIT ||
              rq.gain > GAIN_LIMIT) begin
            pending_err = ST_BAD;
          end else if (rq.freq <= last_freq) begin
            pending_err = ST_ASC;
          end else if (pending_points >= BANK) begin
            pending_err = ST_MANY;
          end else begin
            slot = (live_bank ^ 1) * BANK + pending_points;
            cal_freq[slot] = rq.freq;
            cal_gain[slot] = rq.gain;
            last_freq = rq.freq;
            pending_points++;
          end
        end
        rp.status = pending_err;
        if (rq.last) begin
          if (pending_err == ST_OK) begin
            if (pending_points < 2) begin
              rp.status = ST_FEW;
            end else begin
              live_bank ^= 1;
              table_points = pending_points;
              rp.status = ST_COMMIT;
            end
          end
          pending_points = 0;
          last_freq = 0;
          pending_err = ST_OK;
        end
      end
      OPC_QUERY: rp.gain = bin_correction(rq.bin);
      OPC_CLEAR: table_points = 0;
      default: ;
    endcase
    rp.count = 12'(table_points);
    rp.cal = (table_points >= 2);
    return rp;
  endfunction

  function automatic request_t mk(input opcode_t op, input logic [23:0] freq,
                                  input logic signed [15:0] gain, input logic last,
                                  input logic [15:0] bin);
    request_t rq;
    rq.op = op;
    rq.freq = freq;
    rq.gain = gain;
    rq.last = last;
    rq.bin = bin;
    rq.typed = 0;
    return rq;
  endfunction

  function automatic request_t typed(input request_t rq, input logic [2:0] st,
                                     input logic signed [15:0] g, input logic [11:0] n);
    rq.typed = 1;
    rq.t_status = st;
    rq.t_gain = g;
    rq.t_count = n;
    rq.t_cal = (n >= 2);
    return rq;
  endfunction

  // Offers one request, records its reply when taken, then maybe idles.
  task automatic send(input request_t rq);
    reply_t rp;
    in_tuser  <= rq.op;
    in_tdata  <= {rq.bin, rq.gain, rq.freq};
    in_tlast  <= rq.last;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    rp = apply_request(rq);
    if (rq.typed) begin
      rp.status = rq.t_status;
      rp.gain = rq.t_gain;
      rp.count = rq.t_count;
      rp.cal = rq.t_cal;
    end
    reply_q.push_back(rp);
    sent++;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // Writes one register; the channel drops for a cycle before the next write.
  task automatic write_reg(input logic idx, input logic [19:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_SAMPLE_RATE) rate_hz = val;
    else fft_shift = val[4:0];
    @(posedge clk);
  endtask

  // A well-formed load with ascending points, sometimes spoiled by one bad point.
  task automatic send_load(input int len, input bit spoil);
    logic [23:0] f;
    int unsigned span;
    int          bad_at;
    span = ($urandom_range(0, 2) == 0) ? 2000 : 1500000;
    f = 24'($urandom_range(1, 4000));
    bad_at = spoil ? $urandom_range(0, len - 1) : -1;
    for (int i = 0; i < len; i++) begin
      if (i == bad_at) begin
        case ($urandom_range(0, 2))
          0: send(mk(OPC_LOAD, f, 16'sd25601, i == len - 1, 16'($urandom)));
          1: send(mk(OPC_LOAD, 24'd0, 16'sd0, i == len - 1, 16'($urandom)));
          default: send(mk(OPC_LOAD, f, 16'sd0, i == len - 1, 16'($urandom)));
        endcase
      end else begin
        send(mk(OPC_LOAD, f, 16'($signed($urandom_range(0, 51200)) - 25600),
                i == len - 1, 16'($urandom)));
      end
      f = f + 24'($urandom_range(1, span));
    end
  endtask

  // Clock.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run limit.
  initial begin
    int cycles;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
        $display("FAIL log_freq_calibration_interpolator");
        $finish;
      end
    end
  end

  // Result side: random stalls, one long hold-off, and checking.
  initial begin
    reply_t exp_rp;
    int     stall_left;
    int     hold_left;
    bit     held;
    stall_left = 0;
    hold_left = 0;
    held = 0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        if (reply_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", out_tdata);
        end else begin
          exp_rp = reply_q.pop_front();
          if (out_tdata[2:0] !== exp_rp.status || out_tdata[18:3] !== exp_rp.gain ||
              out_tdata[30:19] !== exp_rp.count || out_tdata[31] !== exp_rp.cal) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp status %0d gain %0d count %0d cal %0d, got %0d %0d %0d %0d",
                       exp_rp.status, exp_rp.gain, exp_rp.count, exp_rp.cal, out_tdata[2:0],
                       $signed(out_tdata[18:3]), out_tdata[30:19], out_tdata[31]);
          end
        end
      end
      if (hold_go && !held) begin
        held = 1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 18);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Request side.
  initial begin
    request_t    plan[$];
    logic [19:0] rates[5];
    logic [4:0]  shifts[5];
    int          phase;
    int          r;
    rates  = '{20'd1000000, 20'd1, 20'd44100, 20'd0, 20'hFFFFF};
    shifts = '{5'd4, 5'd16, 5'd12, 5'd31, 5'd16};
    fill_log_lut();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    in_tlast = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = 1'b0;
    cfg_data = '0;
    mismatches = 0;
    hold_go = 0;
    quiet = 0;
    sent = 0;
    rate_hz = 20'd48000;
    fft_shift = 5'd10;
    live_bank = 0;
    table_points = 0;
    pending_points = 0;
    last_freq = 0;
    pending_err = ST_OK;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: empty table, load errors, a commit, end clamps, interior queries, a clear.
    plan.push_back(typed(mk(OPC_QUERY, 24'd0, 16'sd0, 1'b0, 16'd100), ST_OK, 0, 0));
    plan.push_back(typed(mk(OPC_CLEAR, 24'hFFFFFF, -16'sd1, 1'b1, 16'hFFFF), ST_OK, 0, 0));
    plan.push_back(typed(mk(OPC_NOP, 24'd5, 16'sd5, 1'b1, 16'd5), ST_OK, 0, 0));
    plan.push_back(typed(mk(OPC_LOAD, 24'd0, 16'sd0, 1'b0, 16'd0), ST_BAD, 0, 0));
    plan.push_back(typed(mk(OPC_LOAD, 24'd100, 16'sd0, 1'b1, 16'd0), ST_BAD, 0, 0));
    plan.push_back(typed(mk(OPC_LOAD, 24'd16000000, 16'sd25600, 1'b1, 16'd0), ST_FEW, 0, 0));
    plan.push_back(typed(mk(OPC_LOAD, 24'd16000001, 16'sd0, 1'b1, 16'd0), ST_BAD, 0, 0));
    plan.push_back(typed(mk(OPC_LOAD, 24'd1000, -16'sd25600, 1'b0, 16'd0), ST_OK, 0, 0));
    plan.push_back(typed(mk(OPC_LOAD, 24'd1000, 16'sd0, 1'b0, 16'd0), ST_ASC, 0, 0));
    plan.push_back(typed(mk(OPC_LOAD, 24'd2000, 16'sd0, 1'b1, 16'd0), ST_ASC, 0, 0));
    plan.push_back(typed(mk(OPC_LOAD, 24'd16, -16'sd25601, 1'b1, 16'd0), ST_BAD, 0, 0));
    plan.push_back(typed(mk(OPC_LOAD, 24'd16, -16'sd32768, 1'b1, 16'd0), ST_BAD, 0, 0));
    plan.push_back(typed(mk(OPC_LOAD, 24'd1, 16'sd32767, 1'b1, 16'd0), ST_BAD, 0, 0));
    plan.push_back(typed(mk(OPC_LOAD, 24'd800, -16'sd25600, 1'b0, 16'd0), ST_OK, 0, 0));
    plan.push_back(typed(mk(OPC_LOAD, 24'd16000, 16'sd256, 1'b0, 16'd0), ST_OK, 0, 0));
    plan.push_back(typed(mk(OPC_LOAD, 24'd16000000, 16'sd25600, 1'b1, 16'd0), ST_COMMIT, 0, 3));
    plan.push_back(typed(mk(OPC_QUERY, 24'd0, 16'sd0, 1'b0, 16'd0), ST_OK, -16'sd25600, 3));
    plan.push_back(typed(mk(OPC_QUERY, 24'd0, 16'sd0, 1'b0, 16'hFFFF), ST_OK, 16'sd25600, 3));
    plan.push_back(mk(OPC_QUERY, 24'd0, 16'sd0, 1'b0, 16'd1));
    plan.push_back(mk(OPC_QUERY, 24'd0, 16'sd0, 1'b0, 16'd10));
    plan.push_back(mk(OPC_QUERY, 24'd0, 16'sd0, 1'b0, 16'd300));
    plan.push_back(mk(OPC_QUERY, 24'd0, 16'sd0, 1'b0, 16'd21333));
    plan.push_back(typed(mk(OPC_CLEAR, 24'd0, 16'sd0, 1'b0, 16'd0), ST_OK, 0, 0));
    plan.push_back(typed(mk(OPC_QUERY, 24'd0, 16'sd0, 1'b0, 16'd300), ST_OK, 0, 0));
    foreach (plan[i]) send(plan[i]);
    drain();

    // Random part, with a register change every few hundred requests.
    phase = 0;
    while (sent < RAND_ITEMS) begin
      if (sent >= 300 * (phase + 1) && phase < 5) begin
        drain();
        write_reg(REG_SAMPLE_RATE, rates[phase]);
        write_reg(REG_FFT_LOG2, 20'(shifts[phase]));
        phase++;
      end
      if (sent >= 400) hold_go = 1;
      if (sent >= RAND_ITEMS - 200) quiet = 1;
      r = $urandom_range(0, 99);
      if (r < 40) begin
        send_load($urandom_range(1, 10), $urandom_range(0, 9) == 0);
      end else if (r < 85) begin
        repeat ($urandom_range(1, 6))
          send(mk(OPC_QUERY, 24'($urandom), 16'($urandom), 1'($urandom),
                  ($urandom_range(0, 1) == 0) ? 16'($urandom) : 16'($urandom_range(0, 400))));
      end else if (r < 88) begin
        send(mk(OPC_CLEAR, 24'($urandom), 16'($urandom), 1'($urandom), 16'($urandom)));
      end else if (r < 90) begin
        send(mk(OPC_NOP, 24'($urandom), 16'($urandom), 1'($urandom), 16'($urandom)));
      end else begin
        send(mk(opcode_t'($urandom_range(0, 3)), 24'($urandom), 16'($urandom),
                1'($urandom), 16'($urandom)));
      end
    end
    drain();

    if (mismatches == 0 && reply_q.size() == 0) begin
      $display("PASS log_freq_calibration_interpolator");
    end else begin
      $display("FAIL log_freq_calibration_interpolator");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/lfci_pkg.sv
hw/rtl/lfci_log.sv
hw/rtl/lfci_div.sv
hw/rtl/lfci_dp.sv
hw/rtl/lfci_ctrl.sv
hw/rtl/log_freq_calibration_interpolator.sv
test/tb_top.sv
